### hw/rtl/three_phase_zero_cross_detector_macros.svh
// ----------------------------------------------------------------------------
// zero cross detector assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_ZERO_CROSS_DETECTOR_MACROS_SVH
`define THREE_PHASE_ZERO_CROSS_DETECTOR_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define TPZCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define TPZCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tpzcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpzcd_pkg
// constants and types of the three phase zero cross detector
// ----------------------------------------------------------------------------
package tpzcd_pkg;

    // width of the sample and threshold fields on the ports
    localparam int FIELD_BITS    = 12;
    // bits of each sample that take part in the compare
    localparam int SAMPLE_BITS   = 12;
    // number of newest samples that must agree
    localparam int QUALIFY_COUNT = 4;
    // stored history depth per phase
    localparam int HIST_DEPTH    = (QUALIFY_COUNT > 1) ? QUALIFY_COUNT - 1 : 1;

    localparam logic [FIELD_BITS-1:0] THRESHOLD_RESET = FIELD_BITS'(10);

    typedef logic [FIELD_BITS-1:0]  t_field;
    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [1:0] {
        DET_SEARCH_LOW  = 2'd0,
        DET_FOUND_LOW   = 2'd1,
        DET_SEARCH_HIGH = 2'd2,
        DET_FOUND_HIGH  = 2'd3
    } t_det_state;

    // per phase status for the current transaction
    typedef struct packed {
        logic prime;   // detector in a found state after this scan
        logic left;    // detector left a found state in this scan
    } t_phase_flags;

endpackage

### hw/rtl/tpzcd_scan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpzcd_scan_if
// adc scan channel, one sample per phase
// ----------------------------------------------------------------------------
interface tpzcd_scan_if;
    logic                   valid;
    logic                   ready;
    tpzcd_pkg::t_field      sample_r;
    tpzcd_pkg::t_field      sample_s;
    tpzcd_pkg::t_field      sample_t;

    modport source (output valid, sample_r, sample_s, sample_t, input ready);
    modport sink   (input valid, sample_r, sample_s, sample_t, output ready);
endinterface

### hw/rtl/tpzcd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpzcd_result_if
// result channel, prime pulses and run flag
// ----------------------------------------------------------------------------
interface tpzcd_result_if;
    logic valid;
    logic ready;
    logic prime_r;
    logic prime_s;
    logic prime_t;
    logic run_flag;

    modport source (output valid, prime_r, prime_s, prime_t, run_flag, input ready);
    modport sink   (input valid, prime_r, prime_s, prime_t, run_flag, output ready);
endinterface

### hw/rtl/tpzcd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpzcd_cfg_if
// threshold write channel
// ----------------------------------------------------------------------------
interface tpzcd_cfg_if;
    logic                   valid;
    logic                   ready;
    tpzcd_pkg::t_field      zero_threshold;

    modport source (output valid, zero_threshold, input ready);
    modport sink   (input valid, zero_threshold, output ready);
endinterface

### hw/rtl/tpzcd_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpzcd_phase
// sample history and debounced crossing detector for one phase
// ----------------------------------------------------------------------------
module tpzcd_phase (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  tpzcd_pkg::t_field       i_sample,
    input  tpzcd_pkg::t_sample      i_threshold,
    output tpzcd_pkg::t_phase_flags o_flags
);
    import tpzcd_pkg::*;

    t_sample    r_hist [HIST_DEPTH];
    t_det_state r_det;
    t_det_state n_det;
    t_sample    w_win  [QUALIFY_COUNT];
    logic       w_all_below;
    logic       w_all_above;

    // window: newest sample in slot 0, history behind it
    always_comb begin
        w_win[0] = SAMPLE_BITS'(i_sample);
        for (int i = 1; i < QUALIFY_COUNT; i++) begin
            w_win[i] = r_hist[i-1];
        end
    end

    always_comb begin
        w_all_below = 1'b1;
        w_all_above = 1'b1;
        for (int i = 0; i < QUALIFY_COUNT; i++) begin
            if (!(w_win[i] < i_threshold)) w_all_below = 1'b0;
            if (!(w_win[i] > i_threshold)) w_all_above = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_det = r_det;
        case (r_det)
            DET_SEARCH_LOW: begin
                if (w_all_below) n_det = DET_FOUND_LOW;
            end
            DET_FOUND_LOW:   n_det = DET_SEARCH_HIGH;
            DET_SEARCH_HIGH: begin
                if (w_all_above) n_det = DET_FOUND_HIGH;
            end
            DET_FOUND_HIGH:  n_det = DET_SEARCH_LOW;
            default:         n_det = DET_SEARCH_LOW;
        endcase
    end

    // outputs
    always_comb begin
        o_flags.prime = (n_det == DET_FOUND_LOW) || (n_det == DET_FOUND_HIGH);
        o_flags.left  = (r_det == DET_FOUND_LOW) || (r_det == DET_FOUND_HIGH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det <= DET_SEARCH_LOW;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_en) begin
            r_det <= n_det;
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= w_win[0];
        end
    end

endmodule

### hw/rtl/three_phase_zero_cross_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_zero_cross_detector
// debounced zero crossing detection on three mains phases
// ----------------------------------------------------------------------------
// usage
//   i_scan carries one adc scan per transaction: a sample for phase r, s, t
//   o_result carries one transaction per scan: prime pulse per phase, which
//   is high while that phase sits in a found state, and run_flag, high when
//   any phase left a found state on this scan
//   i_cfg writes zero_threshold; it is always ready and should only be
//   written while no scan is in flight
// latency and throughput
//   a result is presented in the cycle after its scan is taken; one scan per
//   cycle unless stalled, set by the single result register after the compare
// reset
//   histories clear to zero, detectors go to search-low, threshold to 10,
//   the result register empties
// stall
//   a result waits in the output register while o_result.ready is low; a
//   new scan is still taken in the cycle the waiting result is taken
// ----------------------------------------------------------------------------
`include "three_phase_zero_cross_detector_macros.svh"

module three_phase_zero_cross_detector (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tpzcd_scan_if.sink     i_scan,
    tpzcd_result_if.source o_result,
    tpzcd_cfg_if.sink      i_cfg
);
    import tpzcd_pkg::*;

    t_field       r_threshold;
    logic         r_out_valid;
    logic         r_prime_r;
    logic         r_prime_s;
    logic         r_prime_t;
    logic         r_run_flag;

    logic         w_scan_take;
    t_sample      w_threshold;
    t_phase_flags w_flags_r;
    t_phase_flags w_flags_s;
    t_phase_flags w_flags_t;

    // threshold register, writes always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            r_threshold <= i_cfg.zero_threshold;
        end
    end

    // compare only the active sample bits
    assign w_threshold = SAMPLE_BITS'(r_threshold);

    // take a scan when the output register is free or emptying this cycle
    assign i_scan.ready = !r_out_valid || o_result.ready;
    assign w_scan_take  = i_scan.valid && i_scan.ready;

    tpzcd_phase u_phase_r (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_scan_take),
        .i_sample    (i_scan.sample_r),
        .i_threshold (w_threshold),
        .o_flags     (w_flags_r)
    );

    tpzcd_phase u_phase_s (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_scan_take),
        .i_sample    (i_scan.sample_s),
        .i_threshold (w_threshold),
        .o_flags     (w_flags_s)
    );

    tpzcd_phase u_phase_t (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_scan_take),
        .i_sample    (i_scan.sample_t),
        .i_threshold (w_threshold),
        .o_flags     (w_flags_t)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_scan_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each scan
    always_ff @(posedge i_clk) begin
        if (w_scan_take) begin
            r_prime_r  <= w_flags_r.prime;
            r_prime_s  <= w_flags_s.prime;
            r_prime_t  <= w_flags_t.prime;
            r_run_flag <= w_flags_r.left || w_flags_s.left || w_flags_t.left;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.prime_r  = r_prime_r;
    assign o_result.prime_s  = r_prime_s;
    assign o_result.prime_t  = r_prime_t;
    assign o_result.run_flag = r_run_flag;

    // every scan taken shows up as a result the next cycle
    `TPZCD_ASSERT_NEXT(a_scan_gives_result, w_scan_take, o_result.valid,
        "scan taken but no result presented")

    // a phase leaving a found state must raise run_flag on that result
    `TPZCD_ASSERT_NEXT(a_left_sets_run,
        w_scan_take && (w_flags_r.left || w_flags_s.left || w_flags_t.left),
        o_result.run_flag, "phase left found state without run_flag")

    // a stalled result blocks new scans
    `TPZCD_ASSERT_NOW(a_stall_blocks_scan, o_result.valid && !o_result.ready,
        !i_scan.ready, "scan accepted over a stalled result")

endmodule
